// ===== hw/rtl/srt_tick_scheduler_assert.svh =====
// Assertion macros used by the scheduler's top-level RTL file.
`ifndef SRT_TICK_SCHEDULER_ASSERT_SVH
`define SRT_TICK_SCHEDULER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SRT_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define SRT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define SRT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/srt_pkg.sv =====
// Shared constants, types and control structs of the tick scheduler.
package srt_pkg;

   // Table size and time counter width.
   localparam int NUM_TASKS = 5;
   localparam int TIME_BITS = 16;

   // Fixed widths of the channel fields.
   localparam int FIELD_W = 16;
   localparam int TASK_W  = 5;
   localparam int SUM_W   = 21;
   localparam int SUM_MAX = 2097151;

   // Derived widths for indexes, counts and the turnaround accumulator.
   localparam int IDX_W = $clog2(NUM_TASKS);
   localparam int CNT_W = $clog2(NUM_TASKS + 1);
   localparam int ACC_W = TIME_BITS + $clog2(NUM_TASKS);
   localparam int CMP_W = (ACC_W > SUM_W) ? ACC_W : SUM_W;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [FIELD_W-1:0]   field_type;
   typedef logic [TASK_W-1:0]    task_type;
   typedef logic [ACC_W-1:0]     acc_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [SUM_W-1:0]     sum_type;

   localparam idx_type LAST_IDX = idx_type'(NUM_TASKS - 1);

   // Operation codes of an input word.
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic    accept;
      logic    load_wr;
      logic    scan;
      logic    finish;
      idx_type scan_idx;
   } ctrl_cmd_type;

   // Status from the request side back to the controller.
   typedef struct packed {
      logic req_is_load;
   } ctrl_status_type;

endpackage

// ===== hw/rtl/srt_if.sv =====
// Request and response channel interfaces of the tick scheduler.
interface srt_req_if;
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [srt_pkg::TASK_W-1:0]  task_index;
   logic [srt_pkg::FIELD_W-1:0] arrival_time;
   logic [srt_pkg::FIELD_W-1:0] burst_time;

   modport source (output valid, output opcode, output task_index, output arrival_time,
                   output burst_time, input ready);
   modport sink (input valid, input opcode, input task_index, input arrival_time,
                 input burst_time, output ready);
endinterface

interface srt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [srt_pkg::FIELD_W-1:0] current_time;
   logic                        picked_valid;
   logic [srt_pkg::TASK_W-1:0]  picked_task;
   logic [srt_pkg::FIELD_W-1:0] picked_remaining;
   logic                        all_done;
   logic [srt_pkg::SUM_W-1:0]   turnaround_sum;

   modport source (output valid, output current_time, output picked_valid,
                   output picked_task, output picked_remaining, output all_done,
                   output turnaround_sum, input ready);
   modport sink (input valid, input current_time, input picked_valid,
                 input picked_task, input picked_remaining, input all_done,
                 input turnaround_sum, output ready);
endinterface

// ===== hw/rtl/srt_tick_scheduler.sv =====
// Top level of the shortest-remaining-time tick scheduler.
// Each request word is either a load, which writes one task's arrival time and burst into
// the table, or a tick, which activates arriving tasks, runs the active task with the least
// nonzero remaining time (lowest index on a tie), ages every task still runnable and then
// advances the time counter. Every word yields exactly one response word. After acceptance
// a word passes through its table write (loads only), a scan of the table at one entry per
// cycle and a finish step that fills the response register. The next word can be taken in
// the cycle the response appears. A new request is accepted while the previous response
// still waits in the output register; the finish step of the next word waits until that
// register is free.
`include "srt_tick_scheduler_assert.svh"

module srt_tick_scheduler (
   input logic      clock,
   input logic      reset,
   srt_req_if.sink  req_chan,
   srt_rsp_if.source rsp_chan
);
   import srt_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic [3:0]      step_vec;
   logic            req_fire;
   logic            rsp_free;

   assign status.req_is_load = (opcode_type'(req_chan.opcode) == OP_LOAD);

   // Sequencer.
   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // Tables and arithmetic.
   srt_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_opcode           (req_chan.opcode),
      .req_task_index       (req_chan.task_index),
      .req_arrival_time     (req_chan.arrival_time),
      .req_burst_time       (req_chan.burst_time),
      .rsp_current_time     (rsp_chan.current_time),
      .rsp_picked_valid     (rsp_chan.picked_valid),
      .rsp_picked_task      (rsp_chan.picked_task),
      .rsp_picked_remaining (rsp_chan.picked_remaining),
      .rsp_all_done         (rsp_chan.all_done),
      .rsp_turnaround_sum   (rsp_chan.turnaround_sum)
   );

   // Terms watched by the checks below.
   assign step_vec = {cmd.accept, cmd.load_wr, cmd.scan, cmd.finish};
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_chan.valid || rsp_chan.ready;

   // At most one step of the sequence is commanded in any cycle.
   `SRT_ASSERT_ALWAYS(a_one_step, $onehot0(step_vec), "overlapping steps")
   // An accepted word starts with its table write or its first scan cycle.
   `SRT_ASSERT_NEXT(a_start, req_fire, cmd.load_wr || cmd.scan, "word not started")
   // The finish step never overwrites a response that is still waiting.
   `SRT_ASSERT_IMPL(a_no_overwrite, cmd.finish, rsp_free, "response overwritten")
   // The finish step always presents a response.
   `SRT_ASSERT_NEXT(a_finish_resp, cmd.finish, rsp_chan.valid, "response missing after finish")

endmodule

// ===== hw/rtl/srt_ctrl.sv =====
// Sequencer of the tick scheduler: accept, table write, entry scan, finish.
module srt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   input  srt_pkg::ctrl_status_type status,
   output srt_pkg::ctrl_cmd_type    cmd
);
   import srt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   idx_type   scan_idx_ff, scan_idx_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      finish;

   // A word is taken only between items; a pending response does not block it.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // The finish step runs once the output register is free or being emptied.
   assign finish = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // Next state, scan index and response valid.
   always_comb begin
      state_in     = state_ff;
      scan_idx_in  = scan_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in    = status.req_is_load ? ST_LOAD : ST_SCAN;
               scan_idx_in = '0;
            end
         end
         ST_LOAD: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_idx_ff == LAST_IDX) begin
               state_in = ST_FINISH;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Commands decoded from the state.
   always_comb begin
      cmd.accept   = accept;
      cmd.load_wr  = (state_ff == ST_LOAD);
      cmd.scan     = (state_ff == ST_SCAN);
      cmd.finish   = finish;
      cmd.scan_idx = scan_idx_ff;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/srt_dpath.sv =====
// Task tables, scan arithmetic and response register of the tick scheduler.
module srt_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  srt_pkg::ctrl_cmd_type       cmd,
   input  logic                        req_opcode,
   input  logic [srt_pkg::TASK_W-1:0]  req_task_index,
   input  logic [srt_pkg::FIELD_W-1:0] req_arrival_time,
   input  logic [srt_pkg::FIELD_W-1:0] req_burst_time,
   output logic [srt_pkg::FIELD_W-1:0] rsp_current_time,
   output logic                        rsp_picked_valid,
   output logic [srt_pkg::TASK_W-1:0]  rsp_picked_task,
   output logic [srt_pkg::FIELD_W-1:0] rsp_picked_remaining,
   output logic                        rsp_all_done,
   output logic [srt_pkg::SUM_W-1:0]   rsp_turnaround_sum
);
   import srt_pkg::*;

   // Task tables and the time counter.
   time_type               arrival_ff   [NUM_TASKS];
   time_type               remaining_ff [NUM_TASKS];
   time_type               turn_ff      [NUM_TASKS];
   logic [NUM_TASKS-1:0]   active_ff;
   time_type               tick_ff, tick_in;

   // The word being worked on.
   logic      is_tick_ff;
   task_type  ld_idx_ff;
   time_type  ld_arr_ff;
   time_type  ld_burst_ff;
   field_type cur_time_ff;

   // Scan results.
   logic     found_ff, found_in;
   idx_type  best_ff, best_in;
   time_type best_rem_ff, best_rem_in;
   time_type best_turn_ff, best_turn_in;
   logic     best_inc_ff, best_inc_in;
   acc_type  acc_ff, acc_in;
   cnt_type  nz_ff, nz_in;

   // Response register.
   field_type out_time_ff, out_time_in;
   logic      out_valid_ff, out_valid_in;
   task_type  out_task_ff, out_task_in;
   field_type out_rem_ff, out_rem_in;
   logic      out_done_ff, out_done_in;
   sum_type   out_sum_ff, out_sum_in;

   // Entry under scan.
   time_type sc_rem;
   time_type sc_turn;
   time_type sc_turn_in;
   logic     sc_act;
   logic     sc_run;
   logic     sc_better;

   // Finish-step terms.
   logic     ld_ok;
   logic     drop;
   cnt_type  nz_final;
   acc_type  acc_final;
   time_type best_rem_dec;

   // Capture the word at acceptance.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         is_tick_ff  <= (opcode_type'(req_opcode) == OP_TICK);
         ld_idx_ff   <= req_task_index;
         ld_arr_ff   <= time_type'(req_arrival_time);
         ld_burst_ff <= time_type'(req_burst_time);
         cur_time_ff <= field_type'(tick_ff);
      end
   end

   // One table entry per cycle: arrival check, runnability, running minimum.
   always_comb begin
      sc_rem     = remaining_ff[cmd.scan_idx];
      sc_turn    = turn_ff[cmd.scan_idx];
      sc_act     = active_ff[cmd.scan_idx] || (arrival_ff[cmd.scan_idx] == tick_ff);
      sc_run     = is_tick_ff && sc_act && (sc_rem != '0);
      sc_turn_in = (sc_run && (sc_turn != '1)) ? sc_turn + 1'b1 : sc_turn;
      sc_better  = sc_run && (!found_ff || (sc_rem < best_rem_ff));

      found_in     = found_ff;
      best_in      = best_ff;
      best_rem_in  = best_rem_ff;
      best_turn_in = best_turn_ff;
      best_inc_in  = best_inc_ff;
      acc_in       = acc_ff;
      nz_in        = nz_ff;
      if (cmd.accept) begin
         found_in = 1'b0;
         acc_in   = '0;
         nz_in    = '0;
      end else if (cmd.scan) begin
         if (sc_better) begin
            found_in     = 1'b1;
            best_in      = cmd.scan_idx;
            best_rem_in  = sc_rem;
            best_turn_in = sc_turn;
            best_inc_in  = (sc_turn != '1);
         end
         acc_in = acc_ff + acc_type'(sc_turn_in);
         nz_in  = nz_ff + cnt_type'(sc_rem != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_ff      <= best_in;
      best_rem_ff  <= best_rem_in;
      best_turn_ff <= best_turn_in;
      best_inc_ff  <= best_inc_in;
      acc_ff       <= acc_in;
      nz_ff        <= nz_in;
   end

   // The picked task that reaches zero leaves the active set and loses the
   // increment the scan already gave it.
   always_comb begin
      ld_ok        = ({1'b0, ld_idx_ff} < (TASK_W + 1)'(NUM_TASKS));
      drop         = found_ff && (best_rem_ff == time_type'(1));
      best_rem_dec = best_rem_ff - 1'b1;
      nz_final     = nz_ff - cnt_type'(drop);
      acc_final    = acc_ff - acc_type'(drop && best_inc_ff);
      tick_in      = (tick_ff != '1) ? tick_ff + 1'b1 : tick_ff;
   end

   // Table updates: load write, per-entry scan write, finish write.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            remaining_ff[i] <= '0;
            turn_ff[i]      <= '0;
         end
         active_ff <= '0;
         tick_ff   <= '0;
      end else begin
         if (cmd.load_wr && ld_ok) begin
            remaining_ff[ld_idx_ff[IDX_W-1:0]] <= ld_burst_ff;
            turn_ff[ld_idx_ff[IDX_W-1:0]]      <= '0;
            active_ff[ld_idx_ff[IDX_W-1:0]]    <= 1'b0;
         end
         if (cmd.scan && is_tick_ff) begin
            turn_ff[cmd.scan_idx]   <= sc_turn_in;
            active_ff[cmd.scan_idx] <= sc_run;
         end
         if (cmd.finish && is_tick_ff) begin
            tick_ff <= tick_in;
            if (found_ff) begin
               remaining_ff[best_ff] <= best_rem_dec;
            end
            if (drop) begin
               active_ff[best_ff] <= 1'b0;
               turn_ff[best_ff]   <= best_turn_ff;
            end
         end
      end
   end

   // Arrival times have no reset value.
   always_ff @(posedge clock) begin
      if (cmd.load_wr && ld_ok) begin
         arrival_ff[ld_idx_ff[IDX_W-1:0]] <= ld_arr_ff;
      end
   end

   // Response fields formed at the finish step.
   always_comb begin
      out_time_in  = cur_time_ff;
      out_valid_in = found_ff;
      out_task_in  = found_ff ? task_type'(best_ff) : '0;
      out_rem_in   = found_ff ? field_type'(best_rem_dec) : '0;
      out_done_in  = (nz_final == '0);
      if (CMP_W'(acc_final) > CMP_W'(SUM_MAX)) begin
         out_sum_in = sum_type'(SUM_MAX);
      end else begin
         out_sum_in = sum_type'(acc_final);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_time_ff  <= out_time_in;
         out_valid_ff <= out_valid_in;
         out_task_ff  <= out_task_in;
         out_rem_ff   <= out_rem_in;
         out_done_ff  <= out_done_in;
         out_sum_ff   <= out_sum_in;
      end
   end

   assign rsp_current_time     = out_time_ff;
   assign rsp_picked_valid     = out_valid_ff;
   assign rsp_picked_task      = out_task_ff;
   assign rsp_picked_remaining = out_rem_ff;
   assign rsp_all_done         = out_done_ff;
   assign rsp_turnaround_sum   = out_sum_ff;

endmodule
